FILE: hw/rtl/kcrw_pkg.sv
// Types and constants shared by the chi row weight block.
// Holds the transaction payload structs and the row weight table.
// No dependencies.
package kcrw_pkg;

  localparam int unsigned LANE_BITS   = 64;
  localparam int unsigned WEIGHT_W    = 11;
  localparam int unsigned ACTIVE_W    = 9;
  localparam int unsigned PLANE_IDX_W = 3;
  localparam int unsigned ROW_W       = 5;
  localparam int unsigned RW_W        = 3;

  // Rows are summed in groups of eight per stage
  localparam int unsigned GROUP_ROWS  = 8;
  localparam int unsigned GRP_WGT_W   = 6;
  localparam int unsigned GRP_ACT_W   = 4;

  localparam logic [PLANE_IDX_W-1:0] LAST_PLANE = PLANE_IDX_W'(4);

  typedef struct packed {
    logic [LANE_BITS-1:0] lane_x4;
    logic [LANE_BITS-1:0] lane_x3;
    logic [LANE_BITS-1:0] lane_x2;
    logic [LANE_BITS-1:0] lane_x1;
    logic [LANE_BITS-1:0] lane_x0;
  } kcrw_in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_total;
    logic [ACTIVE_W-1:0] active_total;
    logic                state_done;
  } kcrw_out_t;

  localparam logic [RW_W-1:0] ROW_WEIGHT [32] = '{
    3'd0, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
    3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4,
    3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  function automatic logic [RW_W-1:0] row_weight(input logic [ROW_W-1:0] row);
    return ROW_WEIGHT[row];
  endfunction

endpackage

FILE: hw/rtl/keccak_chi_row_weight_sum.sv
// Chi difference weight of a Keccak-f state, one plane per transaction.
// Uses kcrw_pkg for payload types and the row weight table.
//
//  channel | direction | payload    | handshake
//  in_     | input     | kcrw_in_t  | in_valid / in_ready
//  out_    | output    | kcrw_out_t | out_valid / out_ready
//
// One plane accepted per cycle while the output is not stalled; each plane passes
// the input register, group sums and plane sums, then accumulates into the result register.
// Rst_n (synchronous) clears stage valids, plane counter and running totals.
// A stalled result holds in the output register; stages behind it keep
// filling, and in_ready drops only once all four registers are occupied.
module keccak_chi_row_weight_sum
  import kcrw_pkg::*;
#(
  parameter int unsigned LANE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kcrw_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output kcrw_out_t out_data
);

  localparam int unsigned NG   = (LANE_WIDTH + GROUP_ROWS - 1) / GROUP_ROWS;
  localparam int unsigned PW_W = $clog2(4 * LANE_WIDTH + 1);
  localparam int unsigned PA_W = $clog2(LANE_WIDTH + 1);

  logic                       s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  kcrw_in_t                   s1_data_r;
  logic [GRP_WGT_W-1:0]       grp_w_nxt [NG];
  logic [GRP_ACT_W-1:0]       grp_a_nxt [NG];
  logic [GRP_WGT_W-1:0]       grp_w_r   [NG];
  logic [GRP_ACT_W-1:0]       grp_a_r   [NG];
  logic [PW_W-1:0]            psum_w_nxt, psum_w_r;
  logic [PA_W-1:0]            psum_a_nxt, psum_a_r;
  logic [PLANE_IDX_W-1:0]     plane_index_r;
  logic [WEIGHT_W-1:0]        weight_accum_r, weight_nxt;
  logic [ACTIVE_W-1:0]        active_accum_r, active_nxt;
  logic                       last_plane;
  kcrw_out_t                  out_data_r;
  logic                       s2_ready, s3_ready, out_load;

  assign out_load = s3_valid_r && (!out_valid_r || out_ready);
  assign s3_ready = !s3_valid_r || out_load;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // group sums of eight rows
  always_comb begin
    logic [ROW_W-1:0] row;
    int unsigned      z;
    for (int g = 0; g < NG; g++) begin
      grp_w_nxt[g] = '0;
      grp_a_nxt[g] = '0;
      for (int j = 0; j < GROUP_ROWS; j++) begin
        z = g * GROUP_ROWS + j;
        if (z < LANE_WIDTH) begin
          row = {s1_data_r.lane_x4[z], s1_data_r.lane_x3[z], s1_data_r.lane_x2[z],
                 s1_data_r.lane_x1[z], s1_data_r.lane_x0[z]};
          grp_w_nxt[g] = grp_w_nxt[g] + GRP_WGT_W'(row_weight(row));
          grp_a_nxt[g] = grp_a_nxt[g] + GRP_ACT_W'(row != '0);
        end
      end
    end
  end

  always_comb begin
    psum_w_nxt = '0;
    psum_a_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      psum_w_nxt = psum_w_nxt + PW_W'(grp_w_r[g]);
      psum_a_nxt = psum_a_nxt + PA_W'(grp_a_r[g]);
    end
  end

  assign last_plane = (plane_index_r >= LAST_PLANE);
  assign weight_nxt = weight_accum_r + WEIGHT_W'(psum_w_r);
  assign active_nxt = active_accum_r + ACTIVE_W'(psum_a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      s3_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      plane_index_r  <= '0;
      weight_accum_r <= '0;
      active_accum_r <= '0;
    end else begin
      s1_valid_r  <= (in_valid && in_ready) || (s1_valid_r && !s2_ready);
      s2_valid_r  <= (s1_valid_r && s2_ready) || (s2_valid_r && !s3_ready);
      s3_valid_r  <= (s2_valid_r && s3_ready) || (s3_valid_r && !out_load);
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (out_load) begin
        if (last_plane) begin
          plane_index_r  <= '0;
          weight_accum_r <= '0;
          active_accum_r <= '0;
        end else begin
          plane_index_r  <= plane_index_r + PLANE_IDX_W'(1);
          weight_accum_r <= weight_nxt;
          active_accum_r <= active_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_valid_r && s2_ready) begin
      grp_w_r <= grp_w_nxt;
      grp_a_r <= grp_a_nxt;
    end
    if (s2_valid_r && s3_ready) begin
      psum_w_r <= psum_w_nxt;
      psum_a_r <= psum_a_nxt;
    end
    if (out_load) begin
      out_data_r.weight_total <= weight_nxt;
      out_data_r.active_total <= active_nxt;
      out_data_r.state_done   <= last_plane;
    end
  end

  // assertions
  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    plane_index_r <= LAST_PLANE)
    else $error("plane counter beyond last plane");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_plane |=>
      plane_index_r == '0 && weight_accum_r == '0 && active_accum_r == '0)
    else $error("totals not cleared after last plane");

  a_accum_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !last_plane |=>
      weight_accum_r == out_data_r.weight_total &&
      active_accum_r == out_data_r.active_total)
    else $error("running totals differ from delivered result");

  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (12'(out_data_r.weight_total) >= {2'b0, out_data_r.active_total, 1'b0}) &&
      (13'(out_data_r.weight_total) <= {2'b0, out_data_r.active_total, 2'b0}))
    else $error("weight outside two to four per active row");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

endmodule

FILE: bench/keccak_chi_row_weight_sum_tb.sv
// Self-checking bench for keccak_chi_row_weight_sum: random planes and stalls on both channels.
// A scoreboard class tracks running chi weight and active row totals per state.
// Depends on kcrw_pkg and the keccak_chi_row_weight_sum RTL.
module keccak_chi_row_weight_sum_tb;
  import kcrw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANE_W         = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PLANES  = 500;
  localparam int SEGMENT_LEN    = 50;

  class chi_weight_tracker;
    bit [PLANE_IDX_W-1:0] plane_cnt;
    bit [WEIGHT_W-1:0]    weight_run;
    bit [ACTIVE_W-1:0]    active_run;
    kcrw_out_t            expected_totals[$];
    int                   errors;

    function new();
      plane_cnt  = '0;
      weight_run = '0;
      active_run = '0;
      errors     = 0;
    endfunction

    static function bit [2:0] row_cost(bit [4:0] row);
      case (row)
        5'd0: return 3'd0;
        5'd1, 5'd2, 5'd4, 5'd8, 5'd16: return 3'd2;
        5'd7, 5'd14, 5'd15, 5'd19, 5'd23, 5'd24, 5'd25, 5'd27,
        5'd28, 5'd29, 5'd30, 5'd31: return 3'd4;
        default: return 3'd3;
      endcase
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction

    function void note_plane(kcrw_in_t p);
      kcrw_out_t e;
      bit [4:0]  row;
      e.weight_total = weight_run;
      e.active_total = active_run;
      for (int z = 0; z < LANE_W; z++) begin
        row = {p.lane_x4[z], p.lane_x3[z], p.lane_x2[z], p.lane_x1[z], p.lane_x0[z]};
        e.weight_total = e.weight_total + WEIGHT_W'(row_cost(row));
        if (row != 5'd0) e.active_total = e.active_total + ACTIVE_W'(1);
      end
      e.state_done = (plane_cnt >= LAST_PLANE);
      expected_totals.push_back(e);
      if (e.state_done) begin
        plane_cnt  = '0;
        weight_run = '0;
        active_run = '0;
      end else begin
        plane_cnt  = plane_cnt + PLANE_IDX_W'(1);
        weight_run = e.weight_total;
        active_run = e.active_total;
      end
    endfunction

    function void check_totals(kcrw_out_t got);
      kcrw_out_t e;
      if (expected_totals.size() == 0) begin
        $display("%0t: result with no plane outstanding: expected none actual %p", $time, got);
        errors++;
        return;
      end
      e = expected_totals.pop_front();
      if (got.weight_total !== e.weight_total) begin
        $display("%0t: weight_total expected %0d actual %0d", $time,
                 e.weight_total, got.weight_total);
        errors++;
      end
      if (got.active_total !== e.active_total) begin
        $display("%0t: active_total expected %0d actual %0d", $time,
                 e.active_total, got.active_total);
        errors++;
      end
      if (got.state_done !== e.state_done) begin
        $display("%0t: state_done expected %0d actual %0d", $time,
                 e.state_done, got.state_done);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  kcrw_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  kcrw_out_t out_data;

  chi_weight_tracker sb;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  keccak_chi_row_weight_sum #(
    .LANE_WIDTH(LANE_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic kcrw_in_t rows_to_plane(input bit [4:0] rows [LANE_W]);
    kcrw_in_t p;
    p = '0;
    for (int z = 0; z < LANE_W; z++) begin
      p.lane_x0[z] = rows[z][0];
      p.lane_x1[z] = rows[z][1];
      p.lane_x2[z] = rows[z][2];
      p.lane_x3[z] = rows[z][3];
      p.lane_x4[z] = rows[z][4];
    end
    return p;
  endfunction

  function automatic kcrw_in_t random_plane();
    kcrw_in_t p;
    bit [4:0] rows [LANE_W];
    int kind;
    kind = $urandom_range(0, 9);
    p = '0;
    case (kind)
      0, 1, 2, 3: begin
        p = {rand64(), rand64(), rand64(), rand64(), rand64()};
      end
      4, 5: begin
        p.lane_x0 = rand64() | rand64();
        p.lane_x1 = rand64() | rand64();
        p.lane_x2 = rand64() | rand64();
        p.lane_x3 = rand64() | rand64();
        p.lane_x4 = rand64() | rand64();
      end
      6: begin
        p.lane_x0 = rand64() & rand64() & rand64();
        p.lane_x1 = rand64() & rand64() & rand64();
        p.lane_x2 = rand64() & rand64() & rand64();
        p.lane_x3 = rand64() & rand64() & rand64();
        p.lane_x4 = rand64() & rand64() & rand64();
      end
      7: begin
        for (int z = 0; z < LANE_W; z++) rows[z] = 5'd0;
        repeat ($urandom_range(1, 4))
          rows[$urandom_range(0, LANE_W - 1)] = 5'($urandom_range(1, 31));
        p = rows_to_plane(rows);
      end
      8: begin
        case ($urandom_range(0, 2))
          0: p = '1;
          1: p = '0;
          default: p[$urandom_range(0, 4) * LANE_BITS +: LANE_BITS] = rand64();
        endcase
      end
      default: begin
        for (int z = 0; z < LANE_W; z++) rows[z] = 5'($urandom_range(0, 31));
        p = rows_to_plane(rows);
      end
    endcase
    return p;
  endfunction

  task automatic send_plane(input kcrw_in_t p);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_plane(p);
  endtask

  // result side: random back-pressure, held off entirely in quiet stretches
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_totals(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** keccak_chi_row_weight_sum: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    kcrw_in_t p;
    bit [4:0] rows [LANE_W];
    sb = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // state of a zero plane then four full planes, then a fully saturated state
    send_plane('0);
    repeat (4) send_plane('1);
    repeat (5) send_plane('1);

    p = '0;
    p.lane_x0 = '1;
    send_plane(p);
    p = '0;
    p.lane_x4 = 64'h8000_0000_0000_0000;
    send_plane(p);
    for (int z = 0; z < LANE_W; z++) rows[z] = 5'(z % 32);
    send_plane(rows_to_plane(rows));
    for (int z = 0; z < LANE_W; z++) rows[z] = 5'(31 - (z % 32));
    send_plane(rows_to_plane(rows));
    p = {5{64'hAAAA_AAAA_AAAA_AAAA}};
    send_plane(p);
    p = {5{64'h5555_5555_5555_5555}};
    send_plane(p);
    p = {5{64'h8000_0000_0000_0001}};
    send_plane(p);

    for (int n = 0; n < RANDOM_PLANES; n++) begin
      if (n % SEGMENT_LEN == 0) quiet = ($urandom_range(0, 3) == 0);
      send_plane(random_plane());
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** keccak_chi_row_weight_sum: PASSED **");
    end else begin
      $display("** keccak_chi_row_weight_sum: FAILED **");
    end
    $finish;
  end

endmodule
